### rtl/core/dpfc_pkg.sv
`default_nettype none
package dpfc_pkg;
  localparam int PRIME_LIMIT = 65536;
  localparam int PRIME_SLOTS = 8192;
  localparam int MAP_AW = $clog2(PRIME_LIMIT);
  localparam int LIST_AW = $clog2(PRIME_SLOTS);
  localparam int PRIME_W = MAP_AW;
  localparam int NUM_W = 31;
  localparam int CNT_W = 4;
  localparam int POW_W = 10;

  typedef enum logic [3:0] {
    S_CLEAR, S_SIEVE_RD, S_SIEVE_CHK, S_MARK, S_COLLECT_RD, S_COLLECT,
    S_IDLE, S_RD, S_CHK, S_DIV, S_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic zero_rem;
  } div_ctl_t;
endpackage
`default_nettype wire

### rtl/core/dpfc_if.sv
`default_nettype none
interface dpfc_in_if;
  logic valid;
  logic ready;
  logic [30:0] number;
  modport source (output valid, number, input ready);
  modport sink (input valid, number, output ready);
endinterface

interface dpfc_out_if;
  logic valid;
  logic ready;
  logic [3:0] factor_count;
  logic [9:0] power_of_count;
  modport source (output valid, factor_count, power_of_count, input ready);
  modport sink (input valid, factor_count, power_of_count, output ready);
endinterface
`default_nettype wire

### rtl/core/dpfc_ram.sv
`default_nettype none
module dpfc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/core/dpfc_div.sv
`default_nettype none
// restoring divider, one quotient bit a cycle
module dpfc_div import dpfc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [NUM_W-1:0]   dividend,
  input  wire logic [PRIME_W-1:0] divisor,
  output logic                    busy,
  output logic [NUM_W-1:0]        quotient,
  output logic                    zero_rem
);
  localparam int CW = $clog2(NUM_W + 1);
  logic [PRIME_W:0] rem;
  logic [PRIME_W-1:0] dvs;
  logic [CW-1:0] cnt;
  logic [PRIME_W+1:0] trial;

  assign trial = {rem, quotient[NUM_W-1]} - {2'b0, dvs};
  assign zero_rem = (rem == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= CW'(NUM_W);
      rem <= '0;
      quotient <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      if (trial[PRIME_W+1]) begin
        rem <= {rem[PRIME_W-1:0], quotient[NUM_W-1]};
        quotient <= {quotient[NUM_W-2:0], 1'b0};
      end else begin
        rem <= trial[PRIME_W:0];
        quotient <= {quotient[NUM_W-2:0], 1'b1};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) busy <= 1'b0;
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (rst) busy |-> cnt != '0)
    else $error("divider busy with zero count");
endmodule
`default_nettype wire

### rtl/core/distinct_prime_factor_counter_top.sv
`default_nettype none
// per item: each prime tried passes S_RD, S_CHK and a full division in S_DIV, one bit at a time;
//   each repeated division passes S_CHK and S_DIV; up to ~4800 primes for a 31-bit prime input;
//   inputs below 2 go from S_RD to S_DONE; a full output register holds S_DONE until taken
// throughput: one item at a time; the next item is accepted while the result waits
// reset: clearing pass over all 65536 map entries, then the sieve, then the list fill from the map;
//   no item is accepted until the prime list is complete
module distinct_prime_factor_counter_top import dpfc_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  dpfc_in_if.sink   in_ch,
  dpfc_out_if.source out_ch
);
  state_t state, state_next;

  logic [MAP_AW:0] idx;                 // sieve base / list scan
  logic [MAP_AW:0] mul;                 // multiple being marked
  logic [31:0] idx_sq;
  logic [LIST_AW:0] total;
  logic [LIST_AW:0] k;
  logic [NUM_W-1:0] n;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] factor_total;
  logic divided;
  logic walk_stop;

  logic map_we, map_wd, map_rd;
  logic [MAP_AW-1:0] map_wa, map_ra;
  logic list_we;
  logic [LIST_AW-1:0] list_wa, list_ra;
  logic [PRIME_W-1:0] list_rd;

  logic div_start, div_busy, div_zero;
  logic [NUM_W-1:0] quo;
  logic [2*PRIME_W-1:0] sq;

  dpfc_ram #(.WIDTH(1), .DEPTH(PRIME_LIMIT)) u_map (
    .clk, .we(map_we), .waddr(map_wa), .wdata(map_wd), .raddr(map_ra), .rdata(map_rd));
  dpfc_ram #(.WIDTH(PRIME_W), .DEPTH(PRIME_SLOTS)) u_list (
    .clk, .we(list_we), .waddr(list_wa), .wdata(idx[PRIME_W-1:0]), .raddr(list_ra),
    .rdata(list_rd));
  // list_ra stays on k, so list_rd holds the current prime for repeated divisions
  dpfc_div u_div (.clk, .rst, .start(div_start), .dividend(n), .divisor(list_rd),
    .busy(div_busy), .quotient(quo), .zero_rem(div_zero));

  assign idx_sq = 32'(idx) * 32'(idx);
  assign sq = 32'(list_rd) * 32'(list_rd);
  // the square test only applies before the first division by a prime
  assign walk_stop = !divided && (sq > {1'b0, n});
  assign factor_total = count + CNT_W'(n > NUM_W'(1));

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:      if (idx == (MAP_AW+1)'(PRIME_LIMIT-1)) state_next = S_SIEVE_RD;
      S_SIEVE_RD:   state_next = S_SIEVE_CHK;
      S_SIEVE_CHK: begin
        if (idx_sq >= 32'(PRIME_LIMIT)) state_next = S_COLLECT_RD;
        else if (!map_rd) state_next = S_MARK;
        else state_next = S_SIEVE_RD;
      end
      S_MARK:       if (mul + idx >= (MAP_AW+1)'(PRIME_LIMIT)) state_next = S_SIEVE_RD;
      S_COLLECT_RD: state_next = S_COLLECT;
      S_COLLECT: begin
        if (idx == (MAP_AW+1)'(PRIME_LIMIT-1)) state_next = S_IDLE;
        else state_next = S_COLLECT_RD;
      end
      S_IDLE:       if (in_ch.valid) state_next = S_RD;
      S_RD: begin
        if (n < NUM_W'(2) || k >= total) state_next = S_DONE;
        else state_next = S_CHK;
      end
      S_CHK: begin
        if (walk_stop) state_next = S_DONE;
        else state_next = S_DIV;
      end
      S_DIV: begin
        if (!div_busy) begin
          if (div_zero && quo == NUM_W'(1)) state_next = S_DONE;
          else if (div_zero) state_next = S_CHK;
          else state_next = S_RD;
        end
      end
      S_DONE:       if (!out_ch.valid || out_ch.ready) state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  // outputs of control
  always_comb begin
    map_we = 1'b0; map_wd = 1'b1; map_wa = idx[MAP_AW-1:0];
    map_ra = idx[MAP_AW-1:0];
    list_we = 1'b0; list_wa = total[LIST_AW-1:0];
    list_ra = k[LIST_AW-1:0];
    div_start = 1'b0;
    case (state)
      S_CLEAR: begin
        map_we = 1'b1;
        map_wd = (idx < (MAP_AW+1)'(2));
      end
      S_MARK: begin
        map_we = 1'b1;
        map_wa = mul[MAP_AW-1:0];
      end
      S_COLLECT: list_we = !map_rd && idx >= (MAP_AW+1)'(2) &&
                           total < (LIST_AW+1)'(PRIME_SLOTS);
      S_CHK: div_start = !walk_stop;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      idx <= '0;
      total <= '0;
      k <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE && state_next == S_IDLE) out_ch.valid <= 1'b1;
      else if (out_ch.ready) out_ch.valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          if (idx == (MAP_AW+1)'(PRIME_LIMIT-1)) idx <= (MAP_AW+1)'(2);
          else idx <= idx + 1'b1;
        end
        S_SIEVE_CHK: begin
          if (state_next == S_MARK) mul <= idx_sq[MAP_AW:0];
          else if (state_next == S_SIEVE_RD) idx <= idx + 1'b1;
          else idx <= '0;
        end
        S_MARK: begin
          mul <= mul + idx;
          if (state_next == S_SIEVE_RD) idx <= idx + 1'b1;
        end
        S_COLLECT: begin
          if (list_we) total <= total + 1'b1;
          idx <= idx + 1'b1;
        end
        S_IDLE: begin
          if (state_next == S_RD) begin
            n <= in_ch.number;
            k <= '0;
            count <= '0;
            divided <= 1'b0;
          end
        end
        S_DIV: begin
          if (!div_busy) begin
            if (div_zero) begin
              n <= quo;
              if (!divided) count <= count + 1'b1;
              divided <= 1'b1;
            end else begin
              k <= k + 1'b1;
              divided <= 1'b0;
            end
          end
        end
        S_DONE: begin
          if (state_next == S_IDLE) begin
            out_ch.factor_count <= factor_total;
            out_ch.power_of_count <= POW_W'(1) << factor_total;
          end
        end
        default: ;
      endcase
    end
  end

  assign in_ch.ready = (state == S_IDLE);

  a_acc: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> state == S_RD) else $error("accept lost");
  a_done: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE |=> out_ch.valid) else $error("result not shown");
  a_tot: assert property (@(posedge clk) disable iff (rst)
    total <= (LIST_AW+1)'(PRIME_SLOTS)) else $error("list overflow");
endmodule
`default_nettype wire
